### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the sensor reply frame checker.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// ante implies cons in the same cycle
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/srfc_pkg.sv
// Types, constants and the CRC-8 byte update for the sensor reply frame checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srfc_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [3:0] count_type;

   // payload bytes covered by the CRC, held in the byte chain
   localparam int        DATA_BYTES = 8;
   localparam count_type DATA_COUNT = 4'd8;
   // full frame length, check byte included
   localparam count_type FRAME_LEN  = 4'd9;

   localparam byte_type PREFIX_RESET = 8'h3E;
   localparam byte_type OPCODE_RESET = 8'h06;

   // register selects (byte address bit 2)
   localparam logic REG_PREFIX = 1'b0;
   localparam logic REG_OPCODE = 1'b1;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_SHORT        = 3'd1,
      ST_BAD_PREFIX   = 3'd2,
      ST_BAD_OPCODE   = 3'd3,
      ST_CRC_MISMATCH = 3'd4
   } status_type;

   // one shift of the byte chain
   typedef struct packed {
      logic     shift;
      byte_type data;
   } shift_req_type;

   // Dallas/Maxim CRC-8, reflected, one byte per call
   localparam byte_type CRC_BIT_TERMS [8] = '{
      8'h5e, 8'hbc, 8'h61, 8'hc2, 8'h9d, 8'h23, 8'h46, 8'h8c
   };

   function automatic byte_type crc_update(byte_type crc, byte_type b);
      byte_type x;
      byte_type r;
      x = crc ^ b;
      r = '0;
      for (int k = 0; k < 8; k++) begin
         if (x[k]) begin
            r = r ^ CRC_BIT_TERMS[k];
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/srfc_byte_cell.sv
// One byte cell of the frame chain: loads its neighbor's byte on a shift.
// Depends on srfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module srfc_byte_cell (
   input  wire logic               clock,
   input  wire logic               shift,
   input  wire srfc_pkg::byte_type next_byte,
   output srfc_pkg::byte_type      held_byte
);
   import srfc_pkg::*;

   byte_type data_ff;
   byte_type data_in;

   always_comb begin
      data_in = shift ? next_byte : data_ff;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign held_byte = data_ff;

endmodule

`default_nettype wire

### rtl/core/srfc_byte_chain.sv
// Row of byte cells; new bytes enter at the top and move one cell down per shift,
// so after eight shifts cell k holds frame byte k. Depends on srfc_pkg, srfc_byte_cell.
`timescale 1ns / 1ps
`default_nettype none

module srfc_byte_chain (
   input  wire logic                                             clock,
   input  wire srfc_pkg::shift_req_type                          shift_req,
   output srfc_pkg::byte_type [srfc_pkg::DATA_BYTES-1:0]         frame_bytes
);
   import srfc_pkg::*;

   byte_type [DATA_BYTES-1:0] feed;

   genvar i;
   generate
      for (i = 0; i < DATA_BYTES; i++) begin : g_cell
         if (i == DATA_BYTES - 1) begin : g_top
            assign feed[i] = shift_req.data;
         end else begin : g_mid
            assign feed[i] = frame_bytes[i+1];
         end

         srfc_byte_cell u_cell (
            .clock     (clock),
            .shift     (shift_req.shift),
            .next_byte (feed[i]),
            .held_byte (frame_bytes[i])
         );
      end
   endgenerate

endmodule

`default_nettype wire

### rtl/core/sensor_reply_frame_checker_top.sv
// Sensor reply frame checker, top level; depends on srfc_pkg, srfc_byte_chain, assert_macros.svh.
// Throughput: one byte per cycle, every cycle, while the result register is free or drained.
// Latency: a result is valid the cycle after the transfer of the ninth byte, or of
//   a short burst's last byte; all checks are made in the transfer cycle, against the CRC-8 of bytes 0..7.
// Reset (synchronous, active high): frame count, CRC, result valid and the two
//   compare registers (prefix 0x3E, opcode 0x06) return to their reset values.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sensor_reply_frame_checker_top (
   input  wire logic              clock,
   input  wire logic              reset,

   // received bytes
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_rx_byte,
   input  wire logic              req_burst_end,

   // frame results
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [2:0]             rsp_status,
   output logic [7:0]             rsp_node_address,
   output logic signed [7:0]      rsp_temperature,
   output logic [15:0]            rsp_level_value,
   output logic [15:0]            rsp_freq_reading,
   output logic [7:0]             rsp_computed_crc,

   // register port
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [2:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import srfc_pkg::*;

   // ---------------------------------------------------------------
   // Compare registers
   // ---------------------------------------------------------------
   byte_type prefix_ff, prefix_in;
   byte_type opcode_ff, opcode_in;
   logic     csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      prefix_in = prefix_ff;
      opcode_in = opcode_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_PREFIX: prefix_in = csr_pwdata[7:0];
            REG_OPCODE: opcode_in = csr_pwdata[7:0];
            default:    prefix_in = prefix_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_PREFIX: csr_prdata = {24'd0, prefix_ff};
         REG_OPCODE: csr_prdata = {24'd0, opcode_ff};
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= PREFIX_RESET;
         opcode_ff <= OPCODE_RESET;
      end else begin
         prefix_ff <= prefix_in;
         opcode_ff <= opcode_in;
      end
   end

   // ---------------------------------------------------------------
   // Byte intake. The result register parts the two sides: a byte is
   // taken whenever the register is empty or drains this cycle.
   // ---------------------------------------------------------------
   logic      accept;
   logic      in_frame;     // byte 0..7: capture and run CRC
   logic      at_check;     // byte 8: check byte, give frame result
   count_type count_ff, count_in;
   byte_type  crc_ff, crc_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign in_frame  = count_ff < DATA_COUNT;
   assign at_check  = count_ff == DATA_COUNT;

   // frame bytes 0..7 walk down the cell chain
   shift_req_type             shift_req;
   byte_type [DATA_BYTES-1:0] frame_bytes;

   assign shift_req.shift = accept & in_frame;
   assign shift_req.data  = req_rx_byte;

   srfc_byte_chain u_chain (
      .clock       (clock),
      .shift_req   (shift_req),
      .frame_bytes (frame_bytes)
   );

   // count and CRC; burst end rearms, bytes past the ninth are dropped
   always_comb begin
      count_in = count_ff;
      crc_in   = crc_ff;
      if (accept) begin
         if (in_frame) begin
            count_in = count_ff + 4'd1;
            crc_in   = crc_update(crc_ff, req_rx_byte);
         end else if (at_check) begin
            count_in = FRAME_LEN;
         end
         if (req_burst_end) begin
            count_in = '0;
            crc_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff   <= '0;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
      end
   end

   // ---------------------------------------------------------------
   // Result build. Prefix beats opcode beats CRC. A short frame
   // carries zero fields; a full frame always carries the captured bytes.
   // ---------------------------------------------------------------
   logic       new_result;
   status_type status_next;

   assign new_result = accept & ((in_frame & req_burst_end) | at_check);

   always_comb begin
      if (!at_check) begin
         status_next = ST_SHORT;
      end else if (frame_bytes[0] != prefix_ff) begin
         status_next = ST_BAD_PREFIX;
      end else if (frame_bytes[2] != opcode_ff) begin
         status_next = ST_BAD_OPCODE;
      end else if (req_rx_byte != crc_ff) begin
         status_next = ST_CRC_MISMATCH;
      end else begin
         status_next = ST_OK;
      end
   end

   status_type   status_ff, status_in;
   byte_type     address_ff, address_in;
   byte_type     temp_ff, temp_in;
   logic [15:0]  level_ff, level_in;
   logic [15:0]  freq_ff, freq_in;
   byte_type     out_crc_ff, out_crc_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      address_in   = address_ff;
      temp_in      = temp_ff;
      level_in     = level_ff;
      freq_in      = freq_ff;
      out_crc_in   = out_crc_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (new_result) begin
         rsp_valid_in = 1'b1;
         status_in    = status_next;
         if (at_check) begin
            address_in = frame_bytes[1];
            temp_in    = frame_bytes[3];
            level_in   = {frame_bytes[5], frame_bytes[4]};
            freq_in    = {frame_bytes[7], frame_bytes[6]};
            out_crc_in = crc_ff;
         end else begin
            address_in = '0;
            temp_in    = '0;
            level_in   = '0;
            freq_in    = '0;
            out_crc_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      address_ff <= address_in;
      temp_ff    <= temp_in;
      level_ff   <= level_in;
      freq_ff    <= freq_in;
      out_crc_ff <= out_crc_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = 3'(status_ff);
   assign rsp_node_address    = address_ff;
   assign rsp_temperature     = $signed(temp_ff);
   assign rsp_level_value     = level_ff;
   assign rsp_freq_reading    = freq_ff;
   assign rsp_computed_crc    = out_crc_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= FRAME_LEN, "byte count past frame length")
   `ASSERT_NEXT(a_burst_rearm, clock, reset, accept && req_burst_end, count_ff == 4'd0 && crc_ff == 8'd0, "burst end did not rearm")
   `ASSERT_NEXT(a_check_result, clock, reset, accept && at_check, rsp_valid_ff && status_ff != ST_SHORT, "ninth byte gave no frame result")
   `ASSERT_IMPL(a_short_zero, clock, reset, rsp_valid_ff && status_ff == ST_SHORT, out_crc_ff == 8'd0 && address_ff == 8'd0, "short frame with nonzero fields")

endmodule

`default_nettype wire
